@@ design/pts_pkg.sv @@
`timescale 1ns / 1ps

package pts_pkg;

  localparam int TASK_SLOTS_DEF = 8;

  localparam int OP_W       = 3;
  localparam int PRIO_W     = 8;
  localparam int TASK_W     = 3;
  localparam int WORD_W     = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 80;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELAY  = 3'd2;
  localparam logic [OP_W-1:0] OP_ALIVE  = 3'd3;
  localparam logic [OP_W-1:0] OP_SELECT = 3'd4;

  localparam logic [1:0] ST_DEAD    = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_LOWEST = 8'd255;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_rd;
    logic alive_rd;
    logic load_out;
  } pts_cmd_t;

  typedef struct packed {
    logic op_scan;
    logic scan_last;
    logic out_free;
  } pts_stat_t;

endpackage

@@ design/pts_ctrl.sv @@
`timescale 1ns / 1ps

module pts_ctrl import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pts_stat_t stat,
  output pts_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_ARD   = 6'b010000,
    S_AWAIT = 6'b100000
  } fsm_t;

  fsm_t state;
  fsm_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.op_scan ? S_SCAN : S_ARD;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last slot read is processed here
      S_DRAIN: begin
        state_next = S_ARD;
      end
      S_ARD: begin
        cmd.alive_rd = 1'b1;
        state_next   = S_AWAIT;
      end
      S_AWAIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("accepted item did not enter execute");

  a_exec_branch: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> (state == S_SCAN || state == S_ARD))
    else $error("execute left to a wrong state");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_last) |=> state == S_DRAIN)
    else $error("scan overran the last slot");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (state == S_IDLE && !cmd.load_out))
    else $error("result loaded twice");

endmodule

@@ design/pts_dpath.sv @@
`timescale 1ns / 1ps

module pts_dpath import pts_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pts_cmd_t              cmd,
  output pts_stat_t             stat,
  input  logic [OP_W-1:0]       in_op,
  input  logic [PRIO_W-1:0]     in_prio,
  input  logic [TASK_W-1:0]     in_cur,
  input  logic [WORD_W-1:0]     in_ticks,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

  // captured item
  logic [OP_W-1:0]   op_q;
  logic [PRIO_W-1:0] prio_q;
  logic [TASK_W-1:0] cur_q;
  logic [WORD_W-1:0] ticks_q;

  logic [WORD_W-1:0] tick_counter;
  logic [1:0]        slot_state [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] prio_ok;
  logic [TASK_SLOTS-1:0] alive_ok;

  logic [PRIO_W-1:0] prio_mem  [TASK_SLOTS];
  logic [WORD_W-1:0] delay_mem [TASK_SLOTS];
  logic [WORD_W-1:0] alive_mem [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_rd;
  logic [WORD_W-1:0] delay_rd;
  logic [WORD_W-1:0] alive_rd;
  logic              alive_rd_ok;

  // scan pipeline
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] p_idx;
  logic              p_vld;
  logic [SLOT_W-1:0] best;
  logic [PRIO_W-1:0] lead_prio;
  logic              any;
  logic              hit;
  logic [TASK_W-1:0] hit_slot;

  logic [SLOT_W-1:0] cur_idx;
  logic              cur_ok;
  logic              is_add, is_tick, is_pick;
  logic [1:0]        st;
  logic              blk, wake, claim, take;
  logic [1:0]        st_eff;
  logic [WORD_W-1:0] d_next;
  logic [PRIO_W-1:0] p_eff;

  logic [TASK_W-1:0] o_new_slot;
  logic              o_slot_valid;
  logic [TASK_W-1:0] o_next_task;
  logic              o_found;
  logic              o_switch;
  logic [WORD_W-1:0] o_alive;

  assign cur_idx = SLOT_W'(cur_q);
  assign cur_ok  = 32'(cur_q) < TASK_SLOTS;
  assign is_add  = op_q == OP_ADD;
  assign is_tick = op_q == OP_TICK;
  assign is_pick = op_q == OP_TICK || op_q == OP_SELECT;

  assign st     = slot_state[p_idx];
  assign blk    = st == ST_BLOCKED;
  // count down, saturate at zero, wake once zero
  assign d_next = (delay_rd != '0) ? delay_rd - WORD_W'(1) : '0;
  assign wake   = is_tick && blk && (delay_rd == '0 || delay_rd == WORD_W'(1));
  assign st_eff = wake ? ST_READY : st;
  assign p_eff  = prio_ok[p_idx] ? prio_rd : PRIO_LOWEST;
  assign claim  = p_vld && is_add && !hit && st == ST_DEAD;
  assign take   = p_vld && is_pick && st_eff == ST_READY && p_eff <= lead_prio;

  assign stat.op_scan   = is_add || is_pick;
  assign stat.scan_last = idx == LAST_SLOT;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      prio_ok      <= '0;
      alive_ok     <= '0;
      p_vld        <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] <= ST_DEAD;
      end
    end else begin
      p_vld <= cmd.scan_rd;
      if (cmd.exec && is_tick) begin
        tick_counter <= tick_counter + WORD_W'(1);
      end
      if (cmd.exec && op_q == OP_DELAY && cur_ok) begin
        slot_state[cur_idx] <= ST_BLOCKED;
      end
      if (cmd.exec && op_q == OP_ALIVE && cur_ok) begin
        alive_ok[cur_idx] <= 1'b1;
      end
      if (claim) begin
        slot_state[p_idx] <= ST_READY;
        prio_ok[p_idx]    <= 1'b1;
        alive_ok[p_idx]   <= 1'b0;
      end
      if (p_vld && wake) begin
        slot_state[p_idx] <= ST_READY;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= in_op;
      prio_q  <= in_prio;
      cur_q   <= in_cur;
      ticks_q <= in_ticks;
    end
    if (cmd.exec) begin
      idx       <= '0;
      best      <= '0;
      lead_prio <= PRIO_LOWEST;
      any       <= 1'b0;
      hit       <= 1'b0;
      hit_slot  <= '0;
    end
    if (cmd.scan_rd) begin
      p_idx <= idx;
      idx   <= idx + SLOT_W'(1);
    end
    if (claim) begin
      hit      <= 1'b1;
      hit_slot <= TASK_W'(p_idx);
    end
    if (take) begin
      best      <= p_idx;
      lead_prio <= p_eff;
      any       <= 1'b1;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (claim) begin
      prio_mem[p_idx] <= prio_q;
    end
    if (cmd.scan_rd) begin
      prio_rd <= prio_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && op_q == OP_DELAY && cur_ok) begin
      delay_mem[cur_idx] <= ticks_q;
    end else if (p_vld && is_tick && blk) begin
      delay_mem[p_idx] <= d_next;
    end
    if (cmd.scan_rd) begin
      delay_rd <= delay_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && op_q == OP_ALIVE && cur_ok) begin
      alive_mem[cur_idx] <= tick_counter;
    end
    if (cmd.alive_rd) begin
      alive_rd    <= alive_mem[cur_idx];
      alive_rd_ok <= alive_ok[cur_idx];
    end
  end

  always_comb begin
    o_new_slot   = '0;
    o_slot_valid = 1'b0;
    o_next_task  = '0;
    o_found      = 1'b0;
    o_switch     = 1'b0;
    case (op_q) inside
      OP_ADD: begin
        o_new_slot   = hit_slot;
        o_slot_valid = hit;
      end
      OP_TICK, OP_SELECT: begin
        o_next_task = any ? TASK_W'(best) : cur_q;
        o_found     = any;
        o_switch    = is_tick;
      end
      OP_DELAY: begin
        o_switch = 1'b1;
      end
      default: begin
        o_switch = 1'b0;
      end
    endcase
    o_alive = (cur_ok && alive_rd_ok) ? alive_rd : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {7'd0, o_alive, tick_counter, o_switch, o_found, o_next_task,
                   o_slot_valid, o_new_slot};
    end
  end

endmodule

@@ design/priority_task_scheduler_core.sv @@
`timescale 1ns / 1ps
// Add, tick and select pass through execute, a scan of every slot, drain, alive read and output load
// before m_axis_tvalid rises; delay, alive and unused codes skip the scan and drain.
// Items are taken one at a time, paced for scanning ops by the one-slot-a-cycle scan through
// the slot memories; the next item is taken while a result waits.
// Reset: synchronous rst clears all slots to dead (priority 255, stamp 0) and the tick count.
module priority_task_scheduler_core import pts_pkg::*; #(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] task_priority, [10:8] current_task, [42:11] delay_ticks, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] new_slot, [3] slot_valid, [6:4] next_task, [7] found_ready,
  // [8] switch_request, [40:9] tick_value, [72:41] alive_stamp, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pts_dpath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_op     (s_axis_tuser),
    .in_prio   (s_axis_tdata[7:0]),
    .in_cur    (s_axis_tdata[10:8]),
    .in_ticks  (s_axis_tdata[42:11]),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ bench/priority_task_scheduler_core_test.sv @@
`timescale 1ns / 1ps

module priority_task_scheduler_core_test;
  import pts_pkg::*;

  localparam int SLOTS      = TASK_SLOTS_DEF;
  localparam int LATENCY    = SLOTS + 4;
  localparam int HOLD_LEN   = 400;
  localparam int SPARE_OPS  = 3;  // codes above OP_SELECT that do nothing

  typedef struct packed {
    logic [TASK_W-1:0] new_slot;
    logic              slot_valid;
    logic [TASK_W-1:0] next_task;
    logic              found_ready;
    logic              switch_request;
    logic [WORD_W-1:0] tick_value;
    logic [WORD_W-1:0] alive_stamp;
  } sched_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  priority_task_scheduler_core #(
    .TASK_SLOTS(SLOTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // scheduler shadow state
  logic [1:0]        task_state [SLOTS];
  logic [PRIO_W-1:0] task_prio  [SLOTS];
  logic [WORD_W-1:0] task_wait  [SLOTS];
  logic [WORD_W-1:0] task_stamp [SLOTS];
  logic [WORD_W-1:0] tick_count;

  sched_result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_go;
  int hold_left;

  int errors;
  int items_sent;
  int results_seen;
  int slots_claimed;
  int adds_refused;
  int ticks_sent;
  int picks_found;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [TASK_W:0] pick_ready(logic [TASK_W-1:0] cur);
    logic [PRIO_W-1:0] lead_prio;
    logic [TASK_W-1:0] best;
    logic              any;
    lead_prio = PRIO_LOWEST;
    best      = '0;
    any       = 1'b0;
    // ties go to the higher index, so compare with <=
    for (int i = 0; i < SLOTS; i++) begin
      if (task_state[i] == ST_READY && task_prio[i] <= lead_prio) begin
        lead_prio = task_prio[i];
        best      = i[TASK_W-1:0];
        any       = 1'b1;
      end
    end
    return {any, any ? best : cur};
  endfunction

  function automatic sched_result_t sched_predict(logic [OP_W-1:0] op,
                                                  logic [PRIO_W-1:0] prio,
                                                  logic [TASK_W-1:0] cur,
                                                  logic [WORD_W-1:0] ticks);
    sched_result_t r;
    logic          cur_ok;
    r      = '0;
    cur_ok = cur < SLOTS;
    case (op)
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (task_state[i] == ST_DEAD) begin
            task_state[i] = ST_READY;
            task_prio[i]  = prio;
            task_wait[i]  = '0;
            task_stamp[i] = '0;
            r.new_slot    = i[TASK_W-1:0];
            r.slot_valid  = 1'b1;
            break;
          end
        end
      end
      OP_TICK: begin
        tick_count = tick_count + 1;
        for (int i = 0; i < SLOTS; i++) begin
          if (task_state[i] == ST_BLOCKED) begin
            if (task_wait[i] != 0) task_wait[i] = task_wait[i] - 1;
            if (task_wait[i] == 0) task_state[i] = ST_READY;
          end
        end
        {r.found_ready, r.next_task} = pick_ready(cur);
        r.switch_request = 1'b1;
      end
      OP_DELAY: begin
        if (cur_ok) begin
          task_state[cur] = ST_BLOCKED;
          task_wait[cur]  = ticks;
        end
        r.switch_request = 1'b1;
      end
      OP_ALIVE: begin
        if (cur_ok) task_stamp[cur] = tick_count;
      end
      OP_SELECT: begin
        {r.found_ready, r.next_task} = pick_ready(cur);
      end
      default: ;
    endcase
    r.tick_value  = tick_count;
    r.alive_stamp = cur_ok ? task_stamp[cur] : '0;
    return r;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [PRIO_W-1:0] prio,
                           logic [TASK_W-1:0] cur, logic [WORD_W-1:0] ticks);
    sched_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, ticks, cur, prio};
    do @(posedge clk); while (!s_axis_tready);
    r = sched_predict(op, prio, cur, ticks);
    pending_results.push_back(r);
    items_sent++;
    if (op == OP_ADD && r.slot_valid) slots_claimed++;
    if (op == OP_ADD && !r.slot_valid) adds_refused++;
    if (op == OP_TICK) ticks_sent++;
    if (r.found_ready) picks_found++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // receiver: random stalls, or one long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = HOLD_LEN - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.new_slot       = m_axis_tdata[2:0];
      got.slot_valid     = m_axis_tdata[3];
      got.next_task      = m_axis_tdata[6:4];
      got.found_ready    = m_axis_tdata[7];
      got.switch_request = m_axis_tdata[8];
      got.tick_value     = m_axis_tdata[40:9];
      got.alive_stamp    = m_axis_tdata[72:41];
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h at %0t", m_axis_tdata, $realtime);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d at %0t", results_seen, $realtime);
            $display("  expected slot=%0d ok=%0d next=%0d found=%0d sw=%0d tick=%0d stamp=%0d",
                     want.new_slot, want.slot_valid, want.next_task, want.found_ready,
                     want.switch_request, want.tick_value, want.alive_stamp);
            $display("  actual   slot=%0d ok=%0d next=%0d found=%0d sw=%0d tick=%0d stamp=%0d",
                     got.new_slot, got.slot_valid, got.next_task, got.found_ready,
                     got.switch_request, got.tick_value, got.alive_stamp);
          end
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_item(OP_SELECT, 8'd0, 3'd5, 32'd0);       // empty table keeps current
    send_item(OP_TICK, 8'd0, 3'd3, 32'd0);
    send_item(OP_DELAY, 8'd0, 3'd6, 32'd0);        // delay a dead slot
    send_item(OP_ALIVE, 8'd0, 3'd6, 32'd0);
    send_item(OP_TICK, 8'd0, 3'd0, 32'd0);         // zero delay readies here
    send_item(OP_ADD, 8'd255, 3'd0, 32'd0);
    send_item(OP_SELECT, 8'd0, 3'd1, 32'd0);       // tie at priority 255
    send_item(OP_ADD, 8'd0, 3'd0, 32'd0);
    send_item(OP_ADD, 8'd0, 3'd0, 32'd0);
    send_item(OP_SELECT, 8'd0, 3'd0, 32'd0);
    send_item(OP_DELAY, 8'd0, 3'd2, 32'd2);
    send_item(OP_TICK, 8'd0, 3'd2, 32'd0);
    send_item(OP_TICK, 8'd0, 3'd1, 32'd0);
    send_item(OP_ADD, 8'd170, 3'd0, 32'd0);
    send_item(OP_ADD, 8'd85, 3'd0, 32'd0);
    send_item(OP_ADD, 8'd1, 3'd0, 32'd0);
    send_item(OP_ADD, 8'd254, 3'd0, 32'd0);
    send_item(OP_ADD, 8'd0, 3'd0, 32'd0);          // table full
    send_item(OP_ALIVE, 8'd0, 3'd7, 32'd0);
    send_item(OP_DELAY, 8'd0, 3'd1, 32'hFFFF_FFFF);
    for (int k = 1; k <= SPARE_OPS; k++)
      send_item(OP_SELECT + k[OP_W-1:0], 8'hFF, 3'd4, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'd0, 3'd7, 32'd0);
    send_item(OP_SELECT, 8'd0, 3'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(int count);
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] ticks;
    int                pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 5)       op = OP_ADD;
      else if (pick < 40) op = OP_TICK;
      else if (pick < 62) op = OP_DELAY;
      else if (pick < 78) op = OP_ALIVE;
      else if (pick < 94) op = OP_SELECT;
      else                op = OP_SELECT + OP_W'($urandom_range(SPARE_OPS, 1));
      // short delays let blocked tasks come back often
      ticks = ($urandom_range(99) < 85) ? $urandom_range(5) : $urandom;
      send_item(op, PRIO_W'($urandom_range(255)), TASK_W'($urandom_range(SLOTS - 1)),
                ticks);
    end
    drain_results();
  endtask

  task automatic test_output_hold();
    @(posedge clk);
    hold_go = 1'b1;
    test_random_traffic(60);
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_SELECT;
    m_axis_tready  = 1'b0;
    hold_go        = 1'b0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors         = 0;
    items_sent     = 0;
    results_seen   = 0;
    slots_claimed  = 0;
    adds_refused   = 0;
    ticks_sent     = 0;
    picks_found    = 0;
    tick_count     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      task_state[i] = ST_DEAD;
      task_prio[i]  = PRIO_LOWEST;
      task_wait[i]  = '0;
      task_stamp[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic(200);
    send_idle_pct = 86;
    test_random_traffic(150);
    send_idle_pct  = 0;
    recv_stall_pct = 86;
    test_random_traffic(150);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    test_random_traffic(150);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_output_hold();

    $display("sent %0d items, checked %0d results, errors %0d",
             items_sent, results_seen, errors);
    $display("slots claimed %0d, adds refused %0d, ticks %0d, ready picks %0d",
             slots_claimed, adds_refused, ticks_sent, picks_found);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
design/pts_pkg.sv
design/pts_ctrl.sv
design/pts_dpath.sv
design/priority_task_scheduler_core.sv
bench/priority_task_scheduler_core_test.sv
